FILE: sv/pcar_pkg.sv
// Shared types and constants of the PCI configuration access router.
package pcar_pkg;

	// Access commands as carried in the command field.
	typedef enum logic [2:0] {
		CMD_READ32  = 3'd0,
		CMD_READ16  = 3'd1,
		CMD_READ8   = 3'd2,
		CMD_WRITE32 = 3'd3,
		CMD_WRITE16 = 3'd4
	} cmd_t;

	// Route codes of a result item.
	localparam logic [1:0] ROUTE_ECAM   = 2'd0;
	localparam logic [1:0] ROUTE_LEGACY = 2'd1;
	localparam logic [1:0] ROUTE_NONE   = 2'd2;

	// Configuration register indexes; each window takes a base and a range slot.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW0_BASE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW0_RANGE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT  = 3'd4;
	localparam int CFG_WINDOW_STRIDE = 2;
	localparam int CFG_DATA_W = 64;

	// Legacy CF8 enable bit and the highest offset a 16-bit write may use.
	localparam logic [31:0] CF8_ENABLE       = 32'h8000_0000;
	localparam logic [11:0] WRITE16_MAX_OFF  = 12'd4094;
	localparam logic [11:0] LEGACY_OFF_LIMIT = 12'd256;
	localparam logic [15:0] LEGACY_SEGMENT   = 16'd0;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] segment;
		logic [7:0]  bus_number;
		logic [4:0]  device_number;
		logic [2:0]  function_number;
		logic [11:0] register_offset;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [1:0]  route;
		logic [63:0] target_address;
		logic [3:0]  byte_enable;
		logic [31:0] lane_data;
		logic        is_write;
	} rsp_t;

	// Fields of a window range register.
	typedef struct packed {
		logic [7:0]  end_bus;
		logic [7:0]  first_bus;
		logic [15:0] segment;
	} win_range_t;

endpackage

FILE: sv/pcar_if.sv
// Valid/ready channel interfaces for access items and result items.
interface pcar_req_if import pcar_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface pcar_rsp_if import pcar_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/pci_config_access_router_core.sv
// Top level of the PCI configuration access router: ECAM and legacy CF8 decode.
//
// Access items enter on the req channel and one result item per access leaves
// on the rsp channel, both valid/ready; an item moves at a clock edge where
// valid and ready are both high. Each access is captured in an input register,
// decoded by the window compares and one 64-bit address adder, and the result
// is held in an output register. Throughput is one item per cycle while the
// receiver does not stall, set by that two-stage register pipeline, with no
// loop inside it.
// When the receiver stalls, the output register holds its item, the input
// register may still take one more access, and req.ready then drops until the
// stall clears. The ECAM windows and the window count are written through the
// cfg_we/cfg_index/cfg_data port; the user must write them only while no access
// is in flight, and the block does not enforce this. Indexes beyond the register
// list, and window slots beyond WINDOWS, are ignored.
// Reset (arst_n low) empties both pipeline stages and clears all window
// registers, so after reset only the legacy port pair route is available.
module pci_config_access_router_core import pcar_pkg::*; #(
	parameter int WINDOWS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pcar_req_if.sink              req,
	pcar_rsp_if.source            rsp
);

	// Window registers; slot i sits at base index 2*i and range index 2*i+1.
	logic [63:0] win_base_q  [WINDOWS];
	win_range_t  win_range_q [WINDOWS];
	logic [1:0]  window_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOWS; i++) begin
				win_base_q[i]  <= '0;
				win_range_q[i] <= '0;
			end
			window_count_q <= '0;
		end else if (cfg_we) begin
			for (int i = 0; i < WINDOWS; i++) begin
				if (cfg_index == CFG_WINDOW0_BASE + CFG_IDX_W'(CFG_WINDOW_STRIDE * i)) begin
					win_base_q[i] <= cfg_data;
				end
				if (cfg_index == CFG_WINDOW0_RANGE + CFG_IDX_W'(CFG_WINDOW_STRIDE * i)) begin
					win_range_q[i] <= cfg_data[31:0];
				end
			end
			if (cfg_index == CFG_WINDOW_COUNT) begin
				window_count_q <= cfg_data[1:0];
			end
		end
	end

	// Pipeline control: stage 2 moves on when empty or taken, stage 1 when
	// stage 2 can take its item.
	logic valid_s1, valid_s2;
	req_t req_s1;
	rsp_t rsp_s2;
	logic adv_s2, adv_s1;

	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			req_s1 <= req.payload;
		end
	end

	// Decode of the captured access.
	logic        ok;
	logic [3:0]  be;
	logic [31:0] lanes;
	logic        wr;
	logic [WINDOWS-1:0] win_hit;
	logic        any_hit;
	logic [63:0] sel_base;
	logic [7:0]  sel_start;
	logic [27:0] ecam_rel;
	logic [63:0] ecam_addr;
	logic [31:0] legacy_word;
	logic        legacy_ok;
	rsp_t        rsp_d;

	always_comb begin
		ok    = 1'b1;
		be    = '0;
		lanes = '0;
		wr    = 1'b0;
		case (req_s1.command)
			CMD_READ32: begin
				be = 4'hF;
			end
			CMD_READ16: begin
				be = 4'b0011 << {req_s1.register_offset[1], 1'b0};
			end
			CMD_READ8: begin
				be = 4'b0001 << req_s1.register_offset[1:0];
			end
			CMD_WRITE32: begin
				be    = 4'hF;
				lanes = req_s1.write_data;
				wr    = 1'b1;
			end
			CMD_WRITE16: begin
				// An odd offset or one past the last halfword is rejected.
				ok    = !req_s1.register_offset[0] &&
				        (req_s1.register_offset <= WRITE16_MAX_OFF);
				be    = 4'b0011 << {req_s1.register_offset[1], 1'b0};
				lanes = {16'd0, req_s1.write_data[15:0]} <<
				        {req_s1.register_offset[1], 4'd0};
				wr    = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// Window search: the lowest enabled window that matches wins.
	always_comb begin
		for (int i = 0; i < WINDOWS; i++) begin
			win_hit[i] = (int'(window_count_q) > i) &&
			             (win_range_q[i].segment == req_s1.segment) &&
			             (req_s1.bus_number >= win_range_q[i].first_bus) &&
			             (req_s1.bus_number <= win_range_q[i].end_bus);
		end
		any_hit   = |win_hit;
		sel_base  = win_base_q[0];
		sel_start = win_range_q[0].first_bus;
		for (int i = WINDOWS - 1; i >= 0; i--) begin
			if (win_hit[i]) begin
				sel_base  = win_base_q[i];
				sel_start = win_range_q[i].first_bus;
			end
		end
	end

	assign ecam_rel  = {req_s1.bus_number - sel_start, req_s1.device_number,
	                    req_s1.function_number, req_s1.register_offset[11:2], 2'b00};
	assign ecam_addr = sel_base + 64'(ecam_rel);

	assign legacy_word = CF8_ENABLE | {8'd0, req_s1.bus_number, req_s1.device_number,
	                     req_s1.function_number, req_s1.register_offset[7:2], 2'b00};
	assign legacy_ok   = (req_s1.segment == LEGACY_SEGMENT) &&
	                     (req_s1.register_offset < LEGACY_OFF_LIMIT);

	always_comb begin
		rsp_d = '0;
		if (ok && any_hit) begin
			rsp_d.route          = ROUTE_ECAM;
			rsp_d.target_address = ecam_addr;
		end else if (ok && legacy_ok) begin
			rsp_d.route          = ROUTE_LEGACY;
			rsp_d.target_address = {32'd0, legacy_word};
		end else begin
			rsp_d.route = ROUTE_NONE;
		end
		// A dropped access carries no lanes and no write.
		if (rsp_d.route != ROUTE_NONE) begin
			rsp_d.byte_enable = be;
			rsp_d.lane_data   = lanes;
			rsp_d.is_write    = wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp.valid   = valid_s2;
	assign rsp.payload = rsp_s2;

	// A dropped access must show nothing but the route code.
	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.route == ROUTE_NONE |->
		rsp_s2.target_address == '0 && rsp_s2.byte_enable == '0 &&
		rsp_s2.lane_data == '0 && !rsp_s2.is_write)
		else $error("dropped access carries payload");

	// A routed read never carries lane data.
	a_read_no_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.route != ROUTE_NONE && !rsp_s2.is_write |->
		rsp_s2.lane_data == '0)
		else $error("read carries lane data");

	// Every routed access enables at least one byte lane.
	a_routed_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.route != ROUTE_NONE |-> rsp_s2.byte_enable != '0)
		else $error("routed access with no byte lanes");

	// A legacy address word is 32 bits with the enable bit set.
	a_legacy_word: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.route == ROUTE_LEGACY |->
		rsp_s2.target_address[63:32] == '0 && rsp_s2.target_address[31])
		else $error("malformed CF8 address word");

endmodule

FILE: tb/tb.sv
// Self-checking testbench of the PCI configuration access router: ECAM and legacy CF8 decode.
module tb;
	import pcar_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Number of ECAM windows that the block is built with.
	localparam int WINDOWS = 2;

	// Register indexes of the second window follow the first one by the slot stride.
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW1_BASE  =
		CFG_WINDOW0_BASE + CFG_IDX_W'(CFG_WINDOW_STRIDE);
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW1_RANGE =
		CFG_WINDOW0_RANGE + CFG_IDX_W'(CFG_WINDOW_STRIDE);
	// An index past the register list; the block must ignore writes to it.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX  = '1;

	// Command codes past the last defined command; they must come back unrouted.
	localparam logic [2:0] CMD_UNUSED_FIRST = CMD_WRITE16 + 3'd1;
	localparam logic [2:0] CMD_UNUSED_LAST  = '1;

	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 118;
	localparam int PRESSURE_PHASE  = 2;
	localparam int PRESSURE_HOLD   = 200;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pcar_req_if req_ch ();
	pcar_rsp_if rsp_ch ();

	pci_config_access_router_core #(
		.WINDOWS(WINDOWS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Our own copy of the window registers, updated as each write lands.
	logic [63:0] ecam_base [WINDOWS];
	win_range_t ecam_range [WINDOWS];
	logic [1:0] ecam_windows;

	// Accesses waiting to be offered, and decoded results waiting to come back.
	req_t pending_accesses [$];
	rsp_t expected_decodes [$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int mismatches;

	// Set by the monitor when the offered item moved, cleared by the driver.
	bit access_taken;

	// The main sequence arms the long receiver hold once; the ready process counts it.
	bit pressure_arm;
	bit pressure_used;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A run that hangs ends here. The slowest correct run takes well under a tenth of this.
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// Decode one access the way the block should: command checks first, then the
	// windows in order (first match wins), then the legacy port pair, else no route.
	function automatic rsp_t decode_access(req_t a);
		rsp_t r;
		logic ok;
		logic [3:0] lanes;
		logic [31:0] data;
		logic wr;
		int hit;
		int n;
		int i;
		win_range_t w;
		logic [7:0] delta;

		r = '0;
		ok = 1'b1;
		lanes = '0;
		data = '0;
		wr = 1'b0;
		hit = -1;
		case (a.command)
			CMD_READ32: lanes = 4'hF;
			CMD_READ16: lanes = a.register_offset[1] ? 4'hC : 4'h3;
			CMD_READ8: lanes = 4'h1 << a.register_offset[1:0];
			CMD_WRITE32: begin
				lanes = 4'hF;
				data = a.write_data;
				wr = 1'b1;
			end
			CMD_WRITE16: begin
				// A halfword write must be even and must not run past the last halfword.
				ok = !a.register_offset[0] && a.register_offset <= WRITE16_MAX_OFF;
				lanes = a.register_offset[1] ? 4'hC : 4'h3;
				data = a.register_offset[1] ? {a.write_data[15:0], 16'h0000}
					: {16'h0000, a.write_data[15:0]};
				wr = 1'b1;
			end
			default: ok = 1'b0;
		endcase

		r.route = ROUTE_NONE;
		if (ok) begin
			// A window count above the number of windows built searches all of them.
			n = (ecam_windows < WINDOWS) ? ecam_windows : WINDOWS;
			for (i = 0; i < n; i++) begin
				w = ecam_range[i];
				if (hit < 0 && w.segment == a.segment && a.bus_number >= w.first_bus &&
						a.bus_number <= w.end_bus) begin
					hit = i;
				end
			end
			if (hit >= 0) begin
				// The sum wraps at 64 bits; the offset is always dword aligned.
				delta = a.bus_number - ecam_range[hit].first_bus;
				r.route = ROUTE_ECAM;
				r.target_address = ecam_base[hit] + {36'd0, delta, a.device_number,
					a.function_number, a.register_offset[11:2], 2'b00};
			end else if (a.segment == LEGACY_SEGMENT && a.register_offset < LEGACY_OFF_LIMIT) begin
				r.route = ROUTE_LEGACY;
				r.target_address = {32'd0, CF8_ENABLE | {8'd0, a.bus_number, a.device_number,
					a.function_number, a.register_offset[7:2], 2'b00}};
			end
		end
		// Unrouted and rejected accesses carry nothing but the route code.
		if (r.route != ROUTE_NONE) begin
			r.byte_enable = lanes;
			r.lane_data = data;
			r.is_write = wr;
		end
		return r;
	endfunction

	function automatic req_t make_access(logic [2:0] cmd, logic [15:0] seg, logic [7:0] bus,
			logic [4:0] dev, logic [2:0] fn, logic [11:0] off, logic [31:0] wdata);
		req_t a;
		a.command = cmd;
		a.segment = seg;
		a.bus_number = bus;
		a.device_number = dev;
		a.function_number = fn;
		a.register_offset = off;
		a.write_data = wdata;
		return a;
	endfunction

	// Random access aimed mostly at the configured windows and at segment 0, so
	// that hits, bus range edges and legacy accesses all come up often.
	function automatic req_t random_access();
		req_t a;
		int unsigned pick;
		int unsigned roll;
		win_range_t w;

		a.command = ($urandom_range(99) < 4) ? 3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST))
			: 3'($urandom_range(CMD_WRITE16, CMD_READ32));
		a.device_number = 5'($urandom);
		a.function_number = 3'($urandom);
		a.write_data = $urandom;
		pick = $urandom_range(3);
		if (pick < WINDOWS) begin
			w = ecam_range[pick];
			a.segment = w.segment;
			if (w.first_bus <= w.end_bus && $urandom_range(9) != 0) begin
				a.bus_number = 8'($urandom_range(w.end_bus, w.first_bus));
			end else begin
				a.bus_number = 8'($urandom);
			end
		end else begin
			a.segment = (pick == WINDOWS) ? LEGACY_SEGMENT : 16'($urandom);
			a.bus_number = 8'($urandom);
		end
		roll = $urandom_range(99);
		if (roll < 5) begin
			a.register_offset = WRITE16_MAX_OFF + 12'($urandom_range(1));
		end else if (roll < 55) begin
			a.register_offset = 12'($urandom_range(LEGACY_OFF_LIMIT - 1));
		end else begin
			a.register_offset = 12'($urandom);
		end
		return a;
	endfunction

	// Drive one register write; the write enable stays high until the caller drops it.
	task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			CFG_WINDOW0_BASE: ecam_base[0] = value;
			CFG_WINDOW0_RANGE: ecam_range[0] = value[31:0];
			CFG_WINDOW1_BASE: ecam_base[1] = value;
			CFG_WINDOW1_RANGE: ecam_range[1] = value[31:0];
			CFG_WINDOW_COUNT: ecam_windows = value[1:0];
			default: ;
		endcase
	endtask

	// Rewrite every register, plus one write to an unused index that must change nothing.
	task automatic program_windows(logic [63:0] base0, logic [31:0] range0, logic [63:0] base1,
			logic [31:0] range1, logic [1:0] count);
		set_register(CFG_WINDOW0_BASE, base0);
		set_register(CFG_WINDOW0_RANGE, {$urandom, range0});
		set_register(CFG_WINDOW1_BASE, base1);
		set_register(CFG_WINDOW1_RANGE, {$urandom, range1});
		set_register(CFG_WINDOW_COUNT, {{(CFG_DATA_W - 2){1'b0}}, count});
		set_register(CFG_UNUSED_INDEX, {$urandom, $urandom});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// The phase number picks who idles: sender mostly busy and receiver mostly
	// stalled, then the reverse, then a stretch where neither side idles.
	task automatic set_idling(int phase);
		case (phase % 3)
			0: begin
				send_idle_pct = 37;
				recv_idle_pct = 87;
			end
			1: begin
				send_idle_pct = 87;
				recv_idle_pct = 37;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// Wait until every access has been offered and every decode has come back,
	// then let the two pipeline stages settle.
	task automatic wait_drained();
		while (pending_accesses.size() != 0 || req_ch.valid || expected_decodes.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endtask

	// Driver: holds the offered item until it moves, then takes the next one
	// from the queue unless the sender decides to idle this cycle.
	always @(negedge clk) begin
		if (access_taken || !req_ch.valid) begin
			access_taken = 1'b0;
			if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_ch.payload <= pending_accesses.pop_front();
				req_ch.valid <= 1'b1;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold so the pipeline fills and the
	// block has to drop req.ready while the sender keeps offering.
	always @(negedge clk) begin
		if (pressure_arm && !pressure_used) begin
			pressure_used = 1'b1;
			hold_left = PRESSURE_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: every accepted access gets its decode queued, and every accepted
	// result item is compared against the oldest queued decode.
	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				expected_decodes.push_back(decode_access(req_ch.payload));
				access_taken = 1'b1;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.payload;
				if (expected_decodes.size() == 0) begin
					$error("result item arrived with no access outstanding");
					mismatches++;
				end else begin
					want = expected_decodes.pop_front();
					check_field("route", want.route, got.route);
					check_field("target_address", want.target_address, got.target_address);
					check_field("byte_enable", want.byte_enable, got.byte_enable);
					check_field("lane_data", want.lane_data, got.lane_data);
					check_field("is_write", want.is_write, got.is_write);
				end
			end
		end
	end

	initial begin
		logic [31:0] r0;
		logic [31:0] r1;
		logic [63:0] b0;
		logic [63:0] b1;
		logic [1:0] count;

		// Every input known from time zero; reset held low before it is released.
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		rsp_ch.ready = 1'b0;
		mismatches = 0;
		access_taken = 1'b0;
		pressure_arm = 1'b0;
		pressure_used = 1'b0;
		hold_left = 0;
		ecam_base[0] = '0;
		ecam_base[1] = '0;
		ecam_range[0] = '0;
		ecam_range[1] = '0;
		ecam_windows = '0;
		set_idling(0);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Straight out of reset only the legacy pair routes, even for a segment
		// and bus that a zeroed window would otherwise claim.
		pending_accesses.push_back(make_access(CMD_READ32, 16'h0000, 8'h00, 5'd0, 3'd0, 12'h000, 32'h0));
		pending_accesses.push_back(make_access(CMD_WRITE32, 16'h0000, 8'hFF, 5'd31, 3'd7, 12'h0FF,
			32'hFFFF_FFFF));
		wait_drained();

		// Directed part. Window 0 sits at the top of the address space so that
		// its high buses wrap; window 1 covers the upper buses of segment 1.
		set_idling(1);
		program_windows(64'hFFFF_FFFF_FFF0_0000, {8'd7, 8'd0, 16'h0000},
			64'h0000_0000_E000_0000, {8'd255, 8'd16, 16'h0001}, 2'd2);
		// Window hits at the low corner and at the wrapping high corner.
		pending_accesses.push_back(make_access(CMD_READ32, 16'h0000, 8'd0, 5'd0, 3'd0, 12'h000, 32'h0));
		pending_accesses.push_back(make_access(CMD_READ32, 16'h0000, 8'd7, 5'd31, 3'd7, 12'hFFF, 32'h0));
		// Just past window 0 on segment 0 falls back to legacy; halfword and byte lanes.
		pending_accesses.push_back(make_access(CMD_READ16, 16'h0000, 8'd8, 5'd3, 3'd1, 12'h002, 32'h0));
		pending_accesses.push_back(make_access(CMD_READ16, 16'h0000, 8'd8, 5'd3, 3'd1, 12'h001, 32'h0));
		pending_accesses.push_back(make_access(CMD_READ8, 16'h0000, 8'd9, 5'd4, 3'd2, 12'h001, 32'h0));
		pending_accesses.push_back(make_access(CMD_READ8, 16'h0000, 8'd9, 5'd4, 3'd2, 12'h0FE, 32'h0));
		pending_accesses.push_back(make_access(CMD_READ8, 16'h0000, 8'd9, 5'd4, 3'd2, 12'h0FF, 32'h0));
		// Window 1 at both ends of its bus range, with full write data.
		pending_accesses.push_back(make_access(CMD_WRITE32, 16'h0001, 8'd16, 5'd0, 3'd0, 12'h000,
			32'hFFFF_FFFF));
		pending_accesses.push_back(make_access(CMD_WRITE32, 16'h0001, 8'd255, 5'd31, 3'd7, 12'hFFC,
			32'h0000_0000));
		// Halfword writes: both lanes, odd rejected, the top halfword, past it.
		pending_accesses.push_back(make_access(CMD_WRITE16, 16'h0001, 8'd20, 5'd1, 3'd1, 12'h000,
			32'hFFFF_ABCD));
		pending_accesses.push_back(make_access(CMD_WRITE16, 16'h0001, 8'd20, 5'd1, 3'd1, 12'h002,
			32'h1234_FFFF));
		pending_accesses.push_back(make_access(CMD_WRITE16, 16'h0001, 8'd20, 5'd1, 3'd1, 12'h001,
			32'h5A5A_A5A5));
		pending_accesses.push_back(make_access(CMD_WRITE16, 16'h0001, 8'd20, 5'd1, 3'd1, WRITE16_MAX_OFF,
			32'hA5A5_5A5A));
		pending_accesses.push_back(make_access(CMD_WRITE16, 16'h0001, 8'd20, 5'd1, 3'd1, 12'hFFF,
			32'hFFFF_FFFF));
		pending_accesses.push_back(make_access(CMD_WRITE16, 16'h0000, 8'd200, 5'd2, 3'd5, 12'h0FF,
			32'hFFFF_FFFF));
		pending_accesses.push_back(make_access(CMD_WRITE16, 16'h0000, 8'd200, 5'd2, 3'd5, 12'h0FE,
			32'hFFFF_FFFF));
		// Legacy write at the last legacy dword, and the first offset past legacy space.
		pending_accesses.push_back(make_access(CMD_WRITE32, 16'h0000, 8'd200, 5'd17, 3'd6, 12'h0FC,
			32'hDEAD_BEEF));
		pending_accesses.push_back(make_access(CMD_READ32, 16'h0000, 8'd8, 5'd0, 3'd0,
			LEGACY_OFF_LIMIT, 32'h0));
		// No route: foreign segment, and segment 1 below window 1.
		pending_accesses.push_back(make_access(CMD_READ32, 16'hFFFF, 8'd255, 5'd31, 3'd7, 12'h000,
			32'h0));
		pending_accesses.push_back(make_access(CMD_READ8, 16'h0001, 8'd15, 5'd0, 3'd0, 12'h003, 32'h0));
		// Undefined commands on an address that would otherwise route.
		pending_accesses.push_back(make_access(CMD_UNUSED_FIRST, 16'h0000, 8'd0, 5'd0, 3'd0, 12'h000,
			32'hFFFF_FFFF));
		pending_accesses.push_back(make_access(CMD_UNUSED_FIRST + 3'd1, 16'h0000, 8'd1, 5'd0, 3'd0,
			12'h004, 32'hFFFF_FFFF));
		pending_accesses.push_back(make_access(CMD_UNUSED_LAST, 16'h0001, 8'd16, 5'd0, 3'd0, 12'h008,
			32'hFFFF_FFFF));
		wait_drained();

		// Random part, one window setting per phase.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			b0 = {$urandom, $urandom};
			b1 = {$urandom, $urandom};
			r0 = {8'($urandom), 8'($urandom), 16'($urandom_range(2))};
			r1 = {8'($urandom), 8'($urandom), 16'($urandom_range(2))};
			count = 2'($urandom_range(3));
			case (phase)
				0: count = 2'd0;
				1: begin
					// Extreme bases, full bus ranges, and a count above the windows built.
					b0 = '1;
					b1 = '0;
					r0 = {8'hFF, 8'h00, 16'h0000};
					r1 = {8'hFF, 8'h00, 16'hFFFF};
					count = '1;
				end
				2: begin
					// Overlapping windows on segment 0: the first window must win.
					r0 = {8'd20, 8'd10, 16'h0000};
					r1 = {8'hFF, 8'h00, 16'h0000};
					count = 2'd2;
				end
				3: begin
					// Only window 0 is live; window 1 would match but must be ignored.
					r0 = {8'd40, 8'd32, 16'h0001};
					r1 = {8'hFF, 8'h00, 16'h0001};
					count = 2'd1;
				end
				default: ;
			endcase
			set_idling(phase);
			program_windows(b0, r0, b1, r1, count);
			if (phase == PRESSURE_PHASE) begin
				pressure_arm = 1'b1;
			end
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				pending_accesses.push_back(random_access());
			end
			wait_drained();
			pressure_arm = 1'b0;
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/pcar_pkg.sv
sv/pcar_if.sv
sv/pci_config_access_router_core.sv
tb/tb.sv
